// File: sv/cca_pkg.sv
// Package: transaction types, calendar constants and date helper functions.
package cca_pkg;

  typedef enum logic [1:0] {
    OP_SET_TIME = 2'd0,
    OP_SET_DATE = 2'd1,
    OP_ADVANCE  = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [15:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [31:0] amount;
  } in_t;

  typedef struct packed {
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
  } out_t;

  typedef struct packed {
    logic capture;
    logic div_bypass;
    logic div_quo;
    logic div_rem;
    logic apply_time;
    logic apply_adv;
    logic step_day;
    logic conv_hr;
    logic conv_rem;
    logic conv_min;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fits_day;
    logic days_zero;
  } sts_t;

  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

  localparam int unsigned NUM_W = 33;

  localparam int unsigned DAY_PRE    = 7;
  localparam logic [26:0] DAY_RECIP  = 27'd101806633;
  localparam int unsigned DAY_SHIFT  = 36;

  localparam logic [17:0] HOUR_RECIP = 18'd149131;
  localparam int unsigned HOUR_SHIFT = 29;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;
  localparam int unsigned MIN_SHIFT  = 18;

  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [15:0] RST_YEAR  = 16'd2008;

  function automatic logic cca_is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        div25;
    p     = y * INV25;
    div25 = (p <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] cca_days_in_month(input logic [15:0] y,
                                                   input logic [3:0]  m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = cca_is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: sv/calendar_clock_advance.sv
// Top level: real-time clock with calendar, controller plus datapath.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+-----------------
//   input    | in_valid_i  | in_stall_o   | in_data_i  (in_t)
//   output   | out_valid_o | out_stall_i  | out_data_o (out_t)
//
// One transaction at a time. Read or set date: capture, then the hour, remainder and minute split.
// Set time adds the day check and the apply step. Advance also steps one calendar day at a time.
// A set-time total or an advance amount of a day or more adds the divide by 86400.
// Reset: 00:00:00 on day 1, month 1, year 2008; no result pending.
// The result register holds while out_stall_i is high; the next input is taken meanwhile
// and waits in its last cycle until the result register is free.
module calendar_clock_advance
  import cca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  cca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  cca_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: sv/cca_ctrl.sv
// Controller: sequences capture, division, date stepping and time conversion.
module cca_ctrl
  import cca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o,
  output logic out_valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_CHK,
    ST_DIV_Q,
    ST_DIV_R,
    ST_APPLY,
    ST_STEP,
    ST_CONV_HR,
    ST_CONV_REM,
    ST_CONV_MIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          op_d        = in_op_i;
          unique case (in_op_i)
            OP_SET_TIME, OP_ADVANCE: state_d = ST_DIV_CHK;
            OP_SET_DATE, OP_READ:    state_d = ST_CONV_HR;
          endcase
        end
      end
      ST_DIV_CHK: begin
        if (sts_i.fits_day) begin
          cmd.div_bypass = 1'b1;
          state_d        = ST_APPLY;
        end else begin
          state_d = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        cmd.div_quo = 1'b1;
        state_d     = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.div_rem = 1'b1;
        state_d     = ST_APPLY;
      end
      ST_APPLY: begin
        if (op_q == OP_ADVANCE) begin
          cmd.apply_adv = 1'b1;
          state_d       = ST_STEP;
        end else begin
          cmd.apply_time = 1'b1;
          state_d        = ST_CONV_HR;
        end
      end
      ST_STEP: begin
        if (sts_i.days_zero) begin
          state_d = ST_CONV_HR;
        end else begin
          cmd.step_day = 1'b1;
        end
      end
      ST_CONV_HR: begin
        cmd.conv_hr = 1'b1;
        state_d     = ST_CONV_REM;
      end
      ST_CONV_REM: begin
        cmd.conv_rem = 1'b1;
        state_d      = ST_CONV_MIN;
      end
      ST_CONV_MIN: begin
        cmd.conv_min = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd.out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_READ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/cca_dp.sv
// Datapath: clock and calendar registers, reciprocal day divider, time split, result register.
module cca_dp
  import cca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  logic [16:0]      sod_q, sod_d;
  logic [4:0]       day_q, day_d;
  logic [3:0]       month_q, month_d;
  logic [15:0]      year_q, year_d;

  logic [NUM_W-1:0] num_q, num_d;
  logic [16:0]      rem_q, rem_d;
  logic [15:0]      quo_q, quo_d;
  logic [15:0]      days_q, days_d;
  logic [4:0]       hour_q, hour_d;
  logic [11:0]      mrem_q, mrem_d;
  logic [5:0]       min_q, min_d;
  out_t             out_q, out_d;

  logic [NUM_W-1:0] set_sum;
  logic [52:0]      qprod;
  logic [NUM_W-1:0] qmul;
  logic [17:0]      adv_sum;
  logic             adv_wrap;
  logic [4:0]       dim;
  logic [5:0]       day_inc;
  logic [4:0]       month_inc;
  logic [34:0]      hprod;
  logic [24:0]      mprod;
  logic [11:0]      sec_full;

  always_comb begin
    set_sum = NUM_W'(in_data_i.hour_in) * NUM_W'(SECS_PER_HOUR)
            + NUM_W'(in_data_i.minute_in) * NUM_W'(SECS_PER_MIN)
            + NUM_W'(in_data_i.amount);
    qprod    = 53'(num_q[NUM_W-1:DAY_PRE]) * 53'(DAY_RECIP);
    qmul     = NUM_W'(quo_q) * NUM_W'(SECS_PER_DAY);
    adv_sum  = 18'(sod_q) + 18'(rem_q);
    adv_wrap = (adv_sum >= 18'(SECS_PER_DAY));
    dim       = cca_days_in_month(year_q, month_q);
    day_inc   = 6'(day_q) + 6'd1;
    month_inc = 5'(month_q) + 5'd1;
    hprod    = 35'(sod_q) * 35'(HOUR_RECIP);
    mprod    = 25'(mrem_q) * 25'(MIN_RECIP);
    sec_full = mrem_q - 12'(min_q) * 12'(SECS_PER_MIN);
  end

  always_comb begin
    sod_d   = sod_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    days_d  = days_q;
    hour_d  = hour_q;
    mrem_d  = mrem_q;
    min_d   = min_q;
    out_d   = out_q;

    if (cmd_i.capture) begin
      num_d = (in_data_i.op == OP_SET_TIME) ? set_sum : NUM_W'(in_data_i.amount);
      rem_d = '0;
      quo_d = '0;
      if (in_data_i.op == OP_SET_DATE) begin
        year_d  = in_data_i.year_in;
        month_d = in_data_i.month_in;
        day_d   = in_data_i.day_in;
      end
    end

    if (cmd_i.div_bypass) begin
      rem_d = num_q[16:0];
      quo_d = '0;
    end

    if (cmd_i.div_quo) begin
      quo_d = qprod[DAY_SHIFT+15:DAY_SHIFT];
    end

    if (cmd_i.div_rem) begin
      rem_d = 17'(num_q - qmul);
    end

    if (cmd_i.apply_time) begin
      sod_d = rem_q;
    end

    if (cmd_i.apply_adv) begin
      sod_d  = adv_wrap ? 17'(adv_sum - 18'(SECS_PER_DAY)) : adv_sum[16:0];
      days_d = quo_q + 16'(adv_wrap);
    end

    if (cmd_i.step_day) begin
      days_d = days_q - 16'd1;
      if (day_inc > 6'(dim)) begin
        day_d = 5'd1;
        if (month_inc > 5'(MONTHS_PER_YEAR)) begin
          month_d = 4'd1;
          year_d  = year_q + 16'd1;
        end else begin
          month_d = month_inc[3:0];
        end
      end else begin
        day_d = day_inc[4:0];
      end
    end

    if (cmd_i.conv_hr) begin
      hour_d = hprod[HOUR_SHIFT+4:HOUR_SHIFT];
    end

    if (cmd_i.conv_rem) begin
      mrem_d = 12'(sod_q - 17'(hour_q) * 17'(SECS_PER_HOUR));
    end

    if (cmd_i.conv_min) begin
      min_d = mprod[MIN_SHIFT+5:MIN_SHIFT];
    end

    if (cmd_i.out_load) begin
      out_d.out_hour   = hour_q;
      out_d.out_minute = min_q;
      out_d.out_second = sec_full[5:0];
      out_d.out_year   = year_q;
      out_d.out_month  = month_q;
      out_d.out_day    = day_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sod_q   <= '0;
      day_q   <= RST_DAY;
      month_q <= RST_MONTH;
      year_q  <= RST_YEAR;
    end else begin
      sod_q   <= sod_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    days_q <= days_d;
    hour_q <= hour_d;
    mrem_q <= mrem_d;
    min_q  <= min_d;
    out_q  <= out_d;
  end

  assign sts_o.fits_day  = (num_q < NUM_W'(SECS_PER_DAY));
  assign sts_o.days_zero = (days_q == 16'd0);
  assign out_data_o      = out_q;

endmodule
